FILE: rtl/core/sspc_pkg.sv
`timescale 1ns / 1ps

package sspc_pkg;

	localparam logic [7:0]  HDR_BYTE        = 8'hFF;
	localparam logic [15:0] TIMEOUT_RESET   = 16'd250;
	localparam logic [7:0]  BROADCAST_RESET = 8'd254;

	// request kinds carried on s_tuser
	localparam logic [1:0] OP_START = 2'd0;
	localparam logic [1:0] OP_BYTE  = 2'd1;
	localparam logic [1:0] OP_TICK  = 2'd2;

	// completion status
	localparam logic [1:0] ST_OK      = 2'd0;
	localparam logic [1:0] ST_CORRUPT = 2'd1;
	localparam logic [1:0] ST_DEVERR  = 2'd2;
	localparam logic [1:0] ST_TIMEOUT = 2'd3;

	// configuration register indexes
	localparam logic REG_TIMEOUT   = 1'b0;
	localparam logic REG_BROADCAST = 1'b1;

	typedef enum logic [7:0] {
		PH_IDLE  = 8'b0000_0001,
		PH_HDR1  = 8'b0000_0010,
		PH_HDR2  = 8'b0000_0100,
		PH_ID    = 8'b0000_1000,
		PH_LEN   = 8'b0001_0000,
		PH_ERR   = 8'b0010_0000,
		PH_PARAM = 8'b0100_0000,
		PH_CHK   = 8'b1000_0000
	} phase_t;

	typedef struct packed {
		logic       valid;
		logic       param_valid;
		logic [5:0] param_index;
		logic [7:0] param_byte;
		logic       done_res;
		logic [1:0] status_code;
		logic [7:0] device_error;
	} result_t;

endpackage

FILE: rtl/core/sspc_engine.sv
`timescale 1ns / 1ps

module sspc_engine import sspc_pkg::*; #(
	parameter int MAX_PARAMS = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        fire,
	input  logic [1:0]  op,
	input  logic [7:0]  rx_byte,
	input  logic [7:0]  expect_id,
	input  logic [15:0] timeout_ms,
	input  logic [7:0]  bcast_id,
	output result_t     res
);

	localparam logic [8:0] LEN_MAX = 9'(MAX_PARAMS + 2);

	phase_t      phase_q, phase_d;
	logic [7:0]  wanted_id_q, wanted_id_d;
	logic [7:0]  bytes_left_q, bytes_left_d;
	logic [7:0]  sum_q, sum_d;
	logic [5:0]  count_q, count_d;
	logic [15:0] ticks_q, ticks_d;

	always_comb begin
		phase_d      = phase_q;
		wanted_id_d  = wanted_id_q;
		bytes_left_d = bytes_left_q;
		sum_d        = sum_q;
		count_d      = count_q;
		ticks_d      = ticks_q;
		res          = '0;
		case (op)
			OP_START: begin
				wanted_id_d  = expect_id;
				bytes_left_d = '0;
				sum_d        = '0;
				count_d      = '0;
				ticks_d      = '0;
				if (expect_id == bcast_id) begin
					phase_d      = PH_IDLE;
					res.valid    = 1'b1;
					res.done_res = 1'b1;
				end else begin
					phase_d = PH_HDR1;
				end
			end
			OP_TICK: begin
				if (phase_q != PH_IDLE) begin
					// saturate so a full-scale timeout never expires
					if (ticks_q != 16'hFFFF)
						ticks_d = ticks_q + 16'd1;
					if (ticks_d > timeout_ms) begin
						phase_d         = PH_IDLE;
						res.valid       = 1'b1;
						res.done_res    = 1'b1;
						res.status_code = ST_TIMEOUT;
					end
				end
			end
			OP_BYTE: begin
				case (phase_q)
					PH_IDLE: ;
					PH_HDR1, PH_HDR2: begin
						if (rx_byte != HDR_BYTE) begin
							phase_d         = PH_IDLE;
							res.valid       = 1'b1;
							res.done_res    = 1'b1;
							res.status_code = ST_CORRUPT;
						end else begin
							phase_d = (phase_q == PH_HDR1) ? PH_HDR2 : PH_ID;
						end
					end
					PH_ID: begin
						if (rx_byte != wanted_id_q) begin
							phase_d         = PH_IDLE;
							res.valid       = 1'b1;
							res.done_res    = 1'b1;
							res.status_code = ST_CORRUPT;
						end else begin
							sum_d   = rx_byte;
							phase_d = PH_LEN;
						end
					end
					PH_LEN: begin
						if (rx_byte < 8'd2 || {1'b0, rx_byte} > LEN_MAX) begin
							phase_d         = PH_IDLE;
							res.valid       = 1'b1;
							res.done_res    = 1'b1;
							res.status_code = ST_CORRUPT;
						end else begin
							bytes_left_d = rx_byte - 8'd2;
							sum_d        = sum_q + rx_byte;
							phase_d      = PH_ERR;
						end
					end
					PH_ERR: begin
						// check the error byte now, do not wait for the rest
						if (rx_byte != 8'd0) begin
							phase_d          = PH_IDLE;
							res.valid        = 1'b1;
							res.done_res     = 1'b1;
							res.status_code  = ST_DEVERR;
							res.device_error = rx_byte;
						end else begin
							phase_d = (bytes_left_q == 8'd0) ? PH_CHK : PH_PARAM;
						end
					end
					PH_PARAM: begin
						sum_d           = sum_q + rx_byte;
						res.valid       = 1'b1;
						res.param_valid = 1'b1;
						res.param_index = count_q;
						res.param_byte  = rx_byte;
						count_d         = count_q + 6'd1;
						bytes_left_d    = bytes_left_q - 8'd1;
						if (bytes_left_q == 8'd1)
							phase_d = PH_CHK;
					end
					PH_CHK: begin
						phase_d         = PH_IDLE;
						res.valid       = 1'b1;
						res.done_res    = 1'b1;
						res.status_code = (rx_byte != ~sum_q) ? ST_CORRUPT : ST_OK;
					end
					default: begin
						phase_d = PH_IDLE;
					end
				endcase
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q      <= PH_IDLE;
			wanted_id_q  <= '0;
			bytes_left_q <= '0;
			sum_q        <= '0;
			count_q      <= '0;
			ticks_q      <= '0;
		end else if (fire) begin
			phase_q      <= phase_d;
			wanted_id_q  <= wanted_id_d;
			bytes_left_q <= bytes_left_d;
			sum_q        <= sum_d;
			count_q      <= count_d;
			ticks_q      <= ticks_d;
		end
	end

endmodule

FILE: rtl/core/servo_status_packet_checker.sv
`timescale 1ns / 1ps

// Smart-servo status packet checker. Each request (start, received byte or
// millisecond tick) lands in an input register and is parsed there by one
// compare and an 8-bit checksum add; one request is taken every clock unless
// a result stalls. A result reaches the master side via the input register
// and the output register, which lets a new request in while a result still
// waits. A start for the broadcast id finishes at once with success; a
// nonzero error byte ends the packet with device error as soon as it arrives.

module servo_status_packet_checker import sspc_pkg::*; #(
	parameter int MAX_PARAMS = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,   // rx_byte [7:0], expect_id [15:8]
	input  logic [1:0]  s_tuser,   // op [1:0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [23:0] m_tdata,   // param_index [5:0], param_byte [13:6],
	                               // status_code [15:14], device_error [23:16]
	output logic        m_tuser,   // param_valid [0]
	output logic        m_tlast,   // done_res
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [15:0] cfg_data
);

	logic [15:0] timeout_q;
	logic [7:0]  broadcast_q;

	logic        valid_s1;
	logic [1:0]  op_s1;
	logic [7:0]  rx_s1;
	logic [7:0]  eid_s1;

	logic        out_valid_q;
	result_t     out_q;
	result_t     res;
	logic        out_free;
	logic        adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timeout_q   <= TIMEOUT_RESET;
			broadcast_q <= BROADCAST_RESET;
		end else if (cfg_we) begin
			if (cfg_index == REG_TIMEOUT)
				timeout_q <= cfg_data;
			else if (cfg_index == REG_BROADCAST)
				broadcast_q <= cfg_data[7:0];
		end
	end

	assign out_free = !out_valid_q || m_tready;
	// a request with no result never waits for the output side
	assign adv      = valid_s1 && (!res.valid || out_free);
	assign s_tready = !valid_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			op_s1  <= s_tuser;
			rx_s1  <= s_tdata[7:0];
			eid_s1 <= s_tdata[15:8];
		end
	end

	sspc_engine #(
		.MAX_PARAMS(MAX_PARAMS)
	) u_engine (
		.clk         (clk),
		.arst_n      (arst_n),
		.fire        (adv),
		.op          (op_s1),
		.rx_byte     (rx_s1),
		.expect_id   (eid_s1),
		.timeout_ms  (timeout_q),
		.bcast_id    (broadcast_q),
		.res         (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= adv && res.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free && adv && res.valid)
			out_q <= res;
	end

	assign m_tvalid = out_valid_q;
	assign m_tuser  = out_q.param_valid;
	assign m_tlast  = out_q.done_res;
	assign m_tdata  = {out_q.device_error, out_q.status_code,
	                   out_q.param_byte, out_q.param_index};

`ifndef SYNTHESIS
	a_param_not_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser |-> !m_tlast && m_tdata[23:14] == 10'd0)
		else $error("parameter result carries completion fields");

	a_deverr_code: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tlast && m_tdata[15:14] == ST_DEVERR |-> m_tdata[23:16] != 8'd0)
		else $error("device error result without error byte");

	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !adv |=> valid_s1 && $stable(op_s1) && $stable(rx_s1))
		else $error("stalled request lost from input register");
`endif

endmodule
